@@ hdl/ipv4rx_pkg.sv @@
package ipv4rx_pkg;

   localparam int COUNT_WIDTH = 11;
   localparam logic [COUNT_WIDTH-1:0] MAX_FRAME_BYTES = 11'd2047;
   localparam logic [COUNT_WIDTH-1:0] HEADER_BYTES = 11'd20;
   localparam logic [15:0] HEADER_BYTES_WIDE = 16'd20;

   // Byte offsets of the header fields.
   localparam logic [COUNT_WIDTH-1:0] POS_TOTAL_LENGTH_LO = 11'd3;
   localparam logic [COUNT_WIDTH-1:0] POS_PROTOCOL = 11'd9;
   localparam logic [COUNT_WIDTH-1:0] POS_CHECKSUM_LO = 11'd11;
   localparam logic [COUNT_WIDTH-1:0] POS_SOURCE = 11'd12;
   localparam logic [COUNT_WIDTH-1:0] POS_DESTINATION = 11'd16;

   localparam int SLOT_COUNT = 4;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OWN_ADDRESS = 3'd0,
      CSR_NET_MASK    = 3'd1,
      CSR_SLOT0       = 3'd2,
      CSR_SLOT1       = 3'd3,
      CSR_SLOT2       = 3'd4,
      CSR_SLOT3       = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT     = 3'd0,
      VERDICT_SHORT      = 3'd1,
      VERDICT_BAD_SUM    = 3'd2,
      VERDICT_LENGTH     = 3'd3,
      VERDICT_NOT_OURS   = 3'd4,
      VERDICT_NO_HANDLER = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] byte_count;
      logic [15:0]            sum;
      logic [7:0]             high_byte;
      logic [15:0]            checksum;
      logic [15:0]            total_length;
      logic [7:0]             protocol;
      logic [31:0]            source;
      logic [31:0]            destination;
   } frame_type;

   typedef struct packed {
      logic [31:0]                  own_address;
      logic [31:0]                  net_mask;
      logic [SLOT_COUNT-1:0][7:0]   slot_protocol;
   } cfg_type;

   typedef struct packed {
      verdict_type verdict;
      logic [1:0]  handler_slot;
      logic [7:0]  protocol_number;
      logic [31:0] sender_address;
      logic [15:0] payload_length;
   } result_type;

endpackage

@@ hdl/ipv4rx_accum.sv @@
module ipv4rx_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            frame_byte,
   input  logic                  end_of_frame,
   output ipv4rx_pkg::frame_type next_frame
);

   ipv4rx_pkg::frame_type state_ff;
   ipv4rx_pkg::frame_type state_in;
   logic [ipv4rx_pkg::COUNT_WIDTH-1:0] pos;
   logic [15:0] word;
   logic [16:0] wide_sum;
   logic        in_header;

   assign pos = state_ff.byte_count;
   assign word = {state_ff.high_byte, frame_byte};
   assign wide_sum = {1'b0, state_ff.sum} + {1'b0, word};
   assign in_header = (pos < ipv4rx_pkg::HEADER_BYTES);

   always_comb begin
      next_frame = state_ff;
      if (pos < ipv4rx_pkg::MAX_FRAME_BYTES) begin
         next_frame.byte_count = pos + 1'b1;
      end
      if (in_header) begin
         if (!pos[0]) begin
            next_frame.high_byte = frame_byte;
         end else begin
            if (pos == ipv4rx_pkg::POS_CHECKSUM_LO) begin
               next_frame.checksum = word;
            end else begin
               // End-around carry keeps the ones'-complement sum in 16 bits.
               next_frame.sum = wide_sum[15:0] + {15'd0, wide_sum[16]};
            end
            if (pos == ipv4rx_pkg::POS_TOTAL_LENGTH_LO) begin
               next_frame.total_length = word;
            end
         end
         if (pos == ipv4rx_pkg::POS_PROTOCOL) begin
            next_frame.protocol = frame_byte;
         end
         if (pos >= ipv4rx_pkg::POS_SOURCE && pos < ipv4rx_pkg::POS_DESTINATION) begin
            next_frame.source = {state_ff.source[23:0], frame_byte};
         end
         if (pos >= ipv4rx_pkg::POS_DESTINATION) begin
            next_frame.destination = {state_ff.destination[23:0], frame_byte};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         if (end_of_frame) begin
            state_in = '0;
         end else begin
            state_in = next_frame;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/ipv4rx_judge.sv @@
module ipv4rx_judge (
   input  ipv4rx_pkg::frame_type  frame,
   input  ipv4rx_pkg::cfg_type    cfg,
   output ipv4rx_pkg::result_type result
);

   logic [31:0] broadcast;
   logic [15:0] frame_size;
   logic        found;
   logic [1:0]  slot;

   assign broadcast = (cfg.own_address & cfg.net_mask) | ~cfg.net_mask;
   assign frame_size = {{(16 - ipv4rx_pkg::COUNT_WIDTH){1'b0}}, frame.byte_count};

   // Scan from the top so the lowest matching slot wins.
   always_comb begin
      found = 1'b0;
      slot = 2'd0;
      for (int i = ipv4rx_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (frame.protocol != 8'd0 && cfg.slot_protocol[i] == frame.protocol) begin
            found = 1'b1;
            slot = 2'(i);
         end
      end
   end

   always_comb begin
      if (frame.byte_count < ipv4rx_pkg::HEADER_BYTES) begin
         result.verdict = ipv4rx_pkg::VERDICT_SHORT;
      end else if (~frame.sum != frame.checksum) begin
         result.verdict = ipv4rx_pkg::VERDICT_BAD_SUM;
      end else if (frame_size < frame.total_length) begin
         result.verdict = ipv4rx_pkg::VERDICT_LENGTH;
      end else if (frame.destination != cfg.own_address && frame.destination != broadcast) begin
         result.verdict = ipv4rx_pkg::VERDICT_NOT_OURS;
      end else if (!found) begin
         result.verdict = ipv4rx_pkg::VERDICT_NO_HANDLER;
      end else begin
         result.verdict = ipv4rx_pkg::VERDICT_ACCEPT;
      end
      result.handler_slot = (result.verdict == ipv4rx_pkg::VERDICT_ACCEPT) ? slot : 2'd0;
      result.protocol_number = frame.protocol;
      result.sender_address = frame.source;
      if (frame.total_length >= ipv4rx_pkg::HEADER_BYTES_WIDE) begin
         result.payload_length = frame.total_length - ipv4rx_pkg::HEADER_BYTES_WIDE;
      end else begin
         result.payload_length = 16'd0;
      end
   end

endmodule

@@ hdl/ipv4_receive_header_filter.sv @@
// Channel   Direction  Handshake          Word
// req       in         req_valid/stall    frame_byte, end_of_frame
// rsp       out        rsp_valid/stall    verdict, slot, protocol, sender, payload length
// csr       in         csr_valid/ready    register index, 32-bit data
//
// One byte is taken every cycle unless req_stall is high; each byte goes through
// an input register and then updates the header state register. The verdict for
// a frame is judged from the header state and its last byte while that byte sits
// in the input register, and is captured in the result register when it advances.
// Synchronous reset clears the header state, the CSR settings and both valid flags.
// A stalled result holds the input register only while it carries a last byte.
module ipv4_receive_header_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_verdict,
   output logic [1:0]  rsp_handler_slot,
   output logic [7:0]  rsp_protocol_number,
   output logic [31:0] rsp_sender_address,
   output logic [15:0] rsp_payload_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic in_last_ff;
   logic in_load, advance, out_free;

   logic out_valid_ff, out_valid_in;
   ipv4rx_pkg::result_type out_ff;
   ipv4rx_pkg::result_type result;
   ipv4rx_pkg::frame_type next_frame;
   ipv4rx_pkg::cfg_type cfg_ff, cfg_in;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign in_load = req_valid && !req_stall;
   assign in_valid_in = in_load || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && rsp_stall);
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ipv4rx_pkg::CSR_OWN_ADDRESS: cfg_in.own_address = csr_data;
            ipv4rx_pkg::CSR_NET_MASK:    cfg_in.net_mask = csr_data;
            ipv4rx_pkg::CSR_SLOT0:       cfg_in.slot_protocol[0] = csr_data[7:0];
            ipv4rx_pkg::CSR_SLOT1:       cfg_in.slot_protocol[1] = csr_data[7:0];
            ipv4rx_pkg::CSR_SLOT2:       cfg_in.slot_protocol[2] = csr_data[7:0];
            ipv4rx_pkg::CSR_SLOT3:       cfg_in.slot_protocol[3] = csr_data[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   ipv4rx_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .frame_byte   (in_byte_ff),
      .end_of_frame (in_last_ff),
      .next_frame   (next_frame)
   );

   ipv4rx_judge u_judge (
      .frame  (next_frame),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_byte_ff <= req_frame_byte;
         in_last_ff <= req_end_of_frame;
      end
      if (advance && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_verdict = out_ff.verdict;
   assign rsp_handler_slot = out_ff.handler_slot;
   assign rsp_protocol_number = out_ff.protocol_number;
   assign rsp_sender_address = out_ff.sender_address;
   assign rsp_payload_length = out_ff.payload_length;

endmodule

@@ tb/sv/tb_ipv4_receive_header_filter.sv @@
`timescale 1ns / 100ps

module tb_ipv4_receive_header_filter;

   // Tracks the header state of the frame in flight and holds the verdicts still owed.
   class frame_verdict_checker;
      logic [31:0] own_address;
      logic [31:0] net_mask;
      logic [7:0]  slot_protocol[ipv4rx_pkg::SLOT_COUNT];

      logic [ipv4rx_pkg::COUNT_WIDTH-1:0] byte_count;
      logic [15:0] header_sum;
      logic [7:0]  high_byte;
      logic [15:0] received_sum;
      logic [15:0] total_length;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] destination;

      ipv4rx_pkg::result_type pending_verdicts[$];
      int mismatches;
      int verdicts_seen;
      int verdict_hits[6];

      function new();
         int i;
         own_address = '0;
         net_mask = '0;
         for (i = 0; i < ipv4rx_pkg::SLOT_COUNT; i++) slot_protocol[i] = '0;
         for (i = 0; i < 6; i++) verdict_hits[i] = 0;
         mismatches = 0;
         verdicts_seen = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_count = '0;
         header_sum = '0;
         high_byte = '0;
         received_sum = '0;
         total_length = '0;
         protocol = '0;
         source = '0;
         destination = '0;
      endfunction

      function void write_register(ipv4rx_pkg::csr_index_type idx, logic [31:0] data);
         case (idx)
            ipv4rx_pkg::CSR_OWN_ADDRESS: own_address = data;
            ipv4rx_pkg::CSR_NET_MASK:    net_mask = data;
            ipv4rx_pkg::CSR_SLOT0:       slot_protocol[0] = data[7:0];
            ipv4rx_pkg::CSR_SLOT1:       slot_protocol[1] = data[7:0];
            ipv4rx_pkg::CSR_SLOT2:       slot_protocol[2] = data[7:0];
            ipv4rx_pkg::CSR_SLOT3:       slot_protocol[3] = data[7:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      function void take_byte(logic [7:0] value, logic last);
         logic [ipv4rx_pkg::COUNT_WIDTH-1:0] pos;
         logic [15:0] word;
         logic [16:0] acc;
         logic [31:0] bcast;
         logic [1:0]  slot;
         logic        found;
         ipv4rx_pkg::result_type want;
         int i;
         pos = byte_count;
         if (pos < ipv4rx_pkg::HEADER_BYTES) begin
            if (!pos[0]) begin
               high_byte = value;
            end else begin
               word = {high_byte, value};
               // The checksum word itself stays out of the running sum.
               if (pos == ipv4rx_pkg::POS_CHECKSUM_LO) begin
                  received_sum = word;
               end else begin
                  acc = header_sum + word;
                  header_sum = acc[15:0] + acc[16];
               end
               if (pos == ipv4rx_pkg::POS_TOTAL_LENGTH_LO) total_length = word;
            end
            if (pos == ipv4rx_pkg::POS_PROTOCOL) protocol = value;
            if (pos >= ipv4rx_pkg::POS_SOURCE && pos < ipv4rx_pkg::POS_DESTINATION) begin
               source = {source[23:0], value};
            end
            if (pos >= ipv4rx_pkg::POS_DESTINATION) destination = {destination[23:0], value};
         end
         if (byte_count < ipv4rx_pkg::MAX_FRAME_BYTES) byte_count++;
         if (last) begin
            bcast = (own_address & net_mask) | ~net_mask;
            found = 1'b0;
            slot = 2'd0;
            // Walk downward so that the lowest matching slot is the one kept.
            for (i = ipv4rx_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
               if (protocol != 8'd0 && slot_protocol[i] == protocol) begin
                  found = 1'b1;
                  slot = i[1:0];
               end
            end
            if (byte_count < ipv4rx_pkg::HEADER_BYTES)
               want.verdict = ipv4rx_pkg::VERDICT_SHORT;
            else if (~header_sum != received_sum)
               want.verdict = ipv4rx_pkg::VERDICT_BAD_SUM;
            else if ({5'd0, byte_count} < total_length)
               want.verdict = ipv4rx_pkg::VERDICT_LENGTH;
            else if (destination != own_address && destination != bcast)
               want.verdict = ipv4rx_pkg::VERDICT_NOT_OURS;
            else if (!found)
               want.verdict = ipv4rx_pkg::VERDICT_NO_HANDLER;
            else
               want.verdict = ipv4rx_pkg::VERDICT_ACCEPT;
            want.handler_slot = (want.verdict == ipv4rx_pkg::VERDICT_ACCEPT) ? slot : 2'd0;
            want.protocol_number = protocol;
            want.sender_address = source;
            want.payload_length = (total_length >= ipv4rx_pkg::HEADER_BYTES_WIDE) ?
                                  total_length - ipv4rx_pkg::HEADER_BYTES_WIDE : 16'd0;
            pending_verdicts.push_back(want);
            clear_frame();
         end
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s at verdict %0d: expected %h, got %h",
                     field, verdicts_seen, want, got);
      endfunction

      function void compare_verdict(ipv4rx_pkg::result_type got);
         ipv4rx_pkg::result_type want;
         if (int'(got.verdict) < 6) verdict_hits[int'(got.verdict)]++;
         if (pending_verdicts.size() == 0) begin
            flag("verdict with no frame behind it", 32'd0, {29'd0, got.verdict});
         end else begin
            want = pending_verdicts.pop_front();
            if (got.verdict !== want.verdict)
               flag("verdict", {29'd0, want.verdict}, {29'd0, got.verdict});
            if (got.handler_slot !== want.handler_slot)
               flag("handler slot", {30'd0, want.handler_slot}, {30'd0, got.handler_slot});
            if (got.protocol_number !== want.protocol_number)
               flag("protocol", {24'd0, want.protocol_number}, {24'd0, got.protocol_number});
            if (got.sender_address !== want.sender_address)
               flag("sender address", want.sender_address, got.sender_address);
            if (got.payload_length !== want.payload_length)
               flag("payload length", {16'd0, want.payload_length},
                    {16'd0, got.payload_length});
         end
         verdicts_seen++;
      endfunction

      function void close_out();
         if (pending_verdicts.size() != 0) begin
            mismatches += pending_verdicts.size();
            $display("%0d frames never got a verdict", pending_verdicts.size());
         end
      endfunction
   endclass

   typedef enum int {
      FRAME_GOOD,
      FRAME_SHORT,
      FRAME_BAD_SUM,
      FRAME_LONG_TOTAL,
      FRAME_FOREIGN,
      FRAME_NO_PROTOCOL,
      FRAME_TINY_TOTAL,
      FRAME_NOISE
   } frame_kind_type;

   localparam int PHASE_COUNT = 6;
   localparam int PHASE_BYTES = 180;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_frame_byte;
   logic        req_end_of_frame;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_verdict;
   logic [1:0]  rsp_handler_slot;
   logic [7:0]  rsp_protocol_number;
   logic [31:0] rsp_sender_address;
   logic [15:0] rsp_payload_length;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   frame_verdict_checker verdicts;
   logic [7:0] frame_bytes[$];
   bit calm;
   int bytes_sent;
   int frames_sent;

   ipv4_receive_header_filter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_frame_byte      (req_frame_byte),
      .req_end_of_frame    (req_end_of_frame),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_verdict         (rsp_verdict),
      .rsp_handler_slot    (rsp_handler_slot),
      .rsp_protocol_number (rsp_protocol_number),
      .rsp_sender_address  (rsp_sender_address),
      .rsp_payload_length  (rsp_payload_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_gap();
      if (calm || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 6);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_frame_byte   <= value;
      req_end_of_frame <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      verdicts.take_byte(value, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      frames_sent++;
   endtask

   // Fills frame_bytes with random content and, for header-bearing kinds, a header whose
   // fields and checksum are set to aim the frame at the verdict its kind names.
   task automatic build_frame(input frame_kind_type kind, input int size, input int total);
      logic [31:0] bcast;
      logic [31:0] dest;
      logic [15:0] tl;
      logic [15:0] sum;
      logic [15:0] ck;
      logic [16:0] acc;
      logic [7:0]  proto;
      int i;
      frame_bytes.delete();
      for (i = 0; i < size; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (kind != FRAME_SHORT && kind != FRAME_NOISE) begin
         bcast = (verdicts.own_address & verdicts.net_mask) | ~verdicts.net_mask;
         dest = $urandom_range(0, 1) ? verdicts.own_address : bcast;
         proto = verdicts.slot_protocol[$urandom_range(0, ipv4rx_pkg::SLOT_COUNT - 1)];
         if (total >= 0)
            tl = total[15:0];
         else
            tl = 16'($urandom_range(int'(ipv4rx_pkg::HEADER_BYTES), size));
         case (kind)
            FRAME_LONG_TOTAL:
               tl = ($urandom_range(0, 3) == 0) ?
                    16'hFFFF : 16'($urandom_range(size + 1, size + 300));
            FRAME_FOREIGN:     dest = $urandom;
            FRAME_NO_PROTOCOL: proto = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
            FRAME_TINY_TOTAL:  tl = 16'($urandom_range(0, int'(ipv4rx_pkg::HEADER_BYTES) - 1));
            default: ;
         endcase
         frame_bytes[2] = tl[15:8];
         frame_bytes[3] = tl[7:0];
         frame_bytes[9] = proto;
         for (i = 0; i < 4; i++) frame_bytes[16 + i] = dest[31 - 8 * i -: 8];
         sum = 16'd0;
         for (i = 0; i < int'(ipv4rx_pkg::HEADER_BYTES); i += 2) begin
            if (i != 10) begin
               acc = sum + {frame_bytes[i], frame_bytes[i + 1]};
               sum = acc[15:0] + acc[16];
            end
         end
         ck = ~sum;
         if (kind == FRAME_BAD_SUM) ck = ck ^ (16'h0001 << $urandom_range(0, 15));
         frame_bytes[10] = ck[15:8];
         frame_bytes[11] = ck[7:0];
      end
   endtask

   task automatic random_frame();
      int pick;
      frame_kind_type kind;
      int size;
      pick = $urandom_range(0, 99);
      if (pick < 50)      kind = FRAME_GOOD;
      else if (pick < 57) kind = FRAME_SHORT;
      else if (pick < 64) kind = FRAME_BAD_SUM;
      else if (pick < 71) kind = FRAME_LONG_TOTAL;
      else if (pick < 78) kind = FRAME_FOREIGN;
      else if (pick < 86) kind = FRAME_NO_PROTOCOL;
      else if (pick < 93) kind = FRAME_TINY_TOTAL;
      else                kind = FRAME_NOISE;
      if (kind == FRAME_SHORT)
         size = $urandom_range(1, int'(ipv4rx_pkg::HEADER_BYTES) - 1);
      else if (kind == FRAME_NOISE)
         size = $urandom_range(1, 48);
      else
         size = $urandom_range(int'(ipv4rx_pkg::HEADER_BYTES), 40);
      calm = ($urandom_range(0, 4) == 0);
      build_frame(kind, size, -1);
      send_frame();
   endtask

   task automatic write_csr(input ipv4rx_pkg::csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      verdicts.write_register(idx, data);
   endtask

   task automatic apply_settings(input int phase);
      logic [31:0] own;
      logic [31:0] mask;
      logic [7:0]  proto[ipv4rx_pkg::SLOT_COUNT];
      int i;
      case (phase)
         1: begin
            own = 32'hC0A8_0105;
            mask = 32'hFFFF_FF00;
            proto[0] = 8'd6;
            proto[1] = 8'd17;
            proto[2] = 8'd1;
            proto[3] = 8'd6;
         end
         2: begin
            own = 32'hFFFF_FFFF;
            mask = 32'hFFFF_FFFF;
            proto[0] = 8'd255;
            proto[1] = 8'd255;
            proto[2] = 8'd0;
            proto[3] = 8'd1;
         end
         3: begin
            own = 32'h0000_0000;
            mask = 32'h0000_0000;
            proto[0] = 8'd0;
            proto[1] = 8'd0;
            proto[2] = 8'd0;
            proto[3] = 8'd255;
         end
         default: begin
            own = $urandom;
            mask = $urandom_range(0, 3) == 0 ? $urandom : 32'hFFFF_FFFF << $urandom_range(0, 31);
            for (i = 0; i < ipv4rx_pkg::SLOT_COUNT; i++)
               proto[i] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
         end
      endcase
      write_csr(ipv4rx_pkg::CSR_OWN_ADDRESS, own);
      write_csr(ipv4rx_pkg::CSR_NET_MASK, mask);
      for (i = 0; i < ipv4rx_pkg::SLOT_COUNT; i++)
         write_csr(ipv4rx_pkg::csr_index_type'(int'(ipv4rx_pkg::CSR_SLOT0) + i),
                   {24'd0, proto[i]});
      csr_valid <= 1'b0;
   endtask

   // Registers only change with the pipeline empty: every verdict is in and the request side is idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (verdicts.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int hold;
      ipv4rx_pkg::result_type got;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.verdict = ipv4rx_pkg::verdict_type'(rsp_verdict);
            got.handler_slot = rsp_handler_slot;
            got.protocol_number = rsp_protocol_number;
            got.sender_address = rsp_sender_address;
            got.payload_length = rsp_payload_length;
            verdicts.compare_verdict(got);
            hold = draw_gap();
         end else if (rsp_valid === 1'b1 && hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   initial begin
      int phase;
      int start;
      verdicts = new();
      bytes_sent = 0;
      frames_sent = 0;
      calm = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_frame_byte   <= 8'd0;
      req_end_of_frame <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= ipv4rx_pkg::CSR_OWN_ADDRESS;
      csr_data         <= 32'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The first phase runs on the register values left by reset.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            settle();
            apply_settings(phase);
         end
         if (phase == 1) begin
            build_frame(FRAME_SHORT, 1, -1);
            frame_bytes[0] = 8'h00;
            send_frame();
            build_frame(FRAME_SHORT, 3, -1);
            foreach (frame_bytes[i]) frame_bytes[i] = 8'hFF;
            send_frame();
            build_frame(FRAME_GOOD, int'(ipv4rx_pkg::HEADER_BYTES),
                        int'(ipv4rx_pkg::HEADER_BYTES));
            send_frame();
         end
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) random_frame();
      end

      settle();
      repeat (10) @(posedge clock);
      verdicts.close_out();
      $display("Covered %0d bytes in %0d frames over %0d register settings.",
               bytes_sent, frames_sent, PHASE_COUNT);
      $display("Verdicts: accept %0d, short %0d, checksum %0d, length %0d, foreign %0d,",
               verdicts.verdict_hits[0], verdicts.verdict_hits[1], verdicts.verdict_hits[2],
               verdicts.verdict_hits[3], verdicts.verdict_hits[4]);
      $display("unhandled %0d", verdicts.verdict_hits[5]);
      if (verdicts.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Run timed out.");
      $display("FAIL");
      $finish;
   end

endmodule
